// File: sv/sba_pkg.sv
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and constants for the signed arithmetic unit: beat layouts,
// operation and status codes, and the micro-operations of the shared adder.
// ----------------------------------------------------------------------------
package sba_pkg;

   // operand and result width
   localparam int DATA_WIDTH = 16;
   // booth accumulator carries two guard bits
   localparam int ACC_WIDTH  = DATA_WIDTH + 2;
   // step counter for one pass per operand bit
   localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

   // operation codes
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_OVF  = 2'd1;
   localparam logic [1:0] STAT_DIV0 = 2'd2;

   // request beat
   typedef struct packed {
      logic [1:0]                   req_type;
      logic signed [DATA_WIDTH-1:0] operand_a;
      logic signed [DATA_WIDTH-1:0] operand_b;
   } req_beat_type;

   // response beat
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result;
      logic [1:0]                   status;
   } rsp_beat_type;

   // datapath micro-operations
   typedef enum logic [3:0] {
      UOP_NONE       = 4'd0,
      UOP_LOAD_ARITH = 4'd1,
      UOP_LOAD_MUL   = 4'd2,
      UOP_LOAD_DIV   = 4'd3,
      UOP_LOAD_DIV0  = 4'd4,
      UOP_ARITH      = 4'd5,
      UOP_MUL_STEP   = 4'd6,
      UOP_MUL_FIN    = 4'd7,
      UOP_NEG_A      = 4'd8,
      UOP_NEG_B      = 4'd9,
      UOP_DIV_STEP   = 4'd10,
      UOP_DIV_FIX    = 4'd11
   } uop_type;

   // sequencer to datapath and output stage
   typedef struct packed {
      uop_type uop;
      logic    push;
      logic    busy;
   } ctrl_type;

endpackage

// File: sv/sba_datapath.sv
// ----------------------------------------------------------------------------
// sba_datapath
// Working registers and the one shared adder/subtractor. Add and subtract use
// it once, booth multiply and restoring divide use it once per operand bit,
// and the divide sign handling borrows it for the negations.
// ----------------------------------------------------------------------------
module sba_datapath (
   input  logic                  clock,
   input  sba_pkg::uop_type      uop,
   input  sba_pkg::req_beat_type req_data,
   output sba_pkg::rsp_beat_type res_data
);
   import sba_pkg::*;

   logic [ACC_WIDTH-1:0]  acc_ff, acc_in;
   logic [ACC_WIDTH-1:0]  mag_ff, mag_in;
   logic [DATA_WIDTH-1:0] low_ff, low_in;
   logic                  bit_ff, bit_in;
   logic                  flag_ff, flag_in;
   logic [DATA_WIDTH-1:0] res_ff, res_in;
   logic [1:0]            stat_ff, stat_in;

   logic [ACC_WIDTH-1:0]  add_x, add_y, add_sum, step_val, rem_shift;
   logic                  add_sub;
   logic [DATA_WIDTH:0]   prod_top;
   logic                  a_neg, b_neg;

   assign a_neg = req_data.operand_a[DATA_WIDTH-1];
   assign b_neg = req_data.operand_b[DATA_WIDTH-1];

   // partial remainder shifted left with the next dividend bit
   assign rem_shift = {1'b0, acc_ff[DATA_WIDTH-1:0], low_ff[DATA_WIDTH-1]};

   // operand select for the shared adder
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      case (uop)
         UOP_ARITH: begin
            add_x   = acc_ff;
            add_y   = mag_ff;
            add_sub = flag_ff;
         end
         UOP_MUL_STEP: begin
            add_x   = acc_ff;
            add_y   = mag_ff;
            add_sub = low_ff[0];
         end
         UOP_NEG_A: begin
            add_y   = {{2{low_ff[DATA_WIDTH-1]}}, low_ff};
            add_sub = 1'b1;
         end
         UOP_NEG_B: begin
            add_y   = mag_ff;
            add_sub = 1'b1;
         end
         UOP_DIV_STEP: begin
            add_x   = rem_shift;
            add_y   = mag_ff;
            add_sub = 1'b1;
         end
         UOP_DIV_FIX: begin
            add_y   = {2'b00, low_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   // shared adder
   assign add_sum = add_x + (add_y ^ {ACC_WIDTH{add_sub}}) + ACC_WIDTH'(add_sub);

   // booth: add, subtract or keep depending on the recoded bit pair
   assign step_val = (low_ff[0] ^ bit_ff) ? add_sum : acc_ff;

   // product bits that must all match the result sign
   assign prod_top = {acc_ff[DATA_WIDTH-1:0], low_ff[DATA_WIDTH-1]};

   // register updates
   always_comb begin
      acc_in  = acc_ff;
      mag_in  = mag_ff;
      low_in  = low_ff;
      bit_in  = bit_ff;
      flag_in = flag_ff;
      res_in  = res_ff;
      stat_in = stat_ff;
      case (uop)
         UOP_LOAD_ARITH: begin
            acc_in  = {{2{a_neg}}, req_data.operand_a};
            mag_in  = {{2{b_neg}}, req_data.operand_b};
            flag_in = (req_data.req_type == OP_SUB);
         end
         UOP_LOAD_MUL: begin
            acc_in = '0;
            low_in = req_data.operand_b;
            bit_in = 1'b0;
            mag_in = {{2{a_neg}}, req_data.operand_a};
         end
         UOP_LOAD_DIV: begin
            acc_in  = '0;
            low_in  = req_data.operand_a;
            mag_in  = {{2{b_neg}}, req_data.operand_b};
            flag_in = a_neg ^ b_neg;
         end
         UOP_LOAD_DIV0: begin
            res_in  = '0;
            stat_in = STAT_DIV0;
         end
         UOP_ARITH: begin
            res_in  = add_sum[DATA_WIDTH-1:0];
            stat_in = (add_sum[DATA_WIDTH] != add_sum[DATA_WIDTH-1]) ? STAT_OVF : STAT_OK;
         end
         UOP_MUL_STEP: begin
            acc_in = {step_val[ACC_WIDTH-1], step_val[ACC_WIDTH-1:1]};
            low_in = {step_val[0], low_ff[DATA_WIDTH-1:1]};
            bit_in = low_ff[0];
         end
         UOP_MUL_FIN: begin
            res_in  = low_ff;
            stat_in = ((&prod_top) || !(|prod_top)) ? STAT_OK : STAT_OVF;
         end
         UOP_NEG_A: begin
            if (low_ff[DATA_WIDTH-1]) begin
               low_in = add_sum[DATA_WIDTH-1:0];
            end
         end
         UOP_NEG_B: begin
            if (mag_ff[ACC_WIDTH-1]) begin
               mag_in = add_sum;
            end
         end
         UOP_DIV_STEP: begin
            acc_in = add_sum[ACC_WIDTH-1] ? rem_shift : add_sum;
            low_in = {low_ff[DATA_WIDTH-2:0], ~add_sum[ACC_WIDTH-1]};
         end
         UOP_DIV_FIX: begin
            res_in  = flag_ff ? add_sum[DATA_WIDTH-1:0] : low_ff;
            stat_in = (!flag_ff && low_ff[DATA_WIDTH-1]) ? STAT_OVF : STAT_OK;
         end
         default: begin
            res_in = res_ff;
         end
      endcase
   end

   // working registers, payload only
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      mag_ff  <= mag_in;
      low_ff  <= low_in;
      bit_ff  <= bit_in;
      flag_ff <= flag_in;
      res_ff  <= res_in;
      stat_ff <= stat_in;
   end

   assign res_data.result = res_ff;
   assign res_data.status = stat_ff;

endmodule

// File: sv/sba_ctrl.sv
// ----------------------------------------------------------------------------
// sba_ctrl
// Sequencer for the shared adder: picks the micro-operation per cycle, counts
// the per-bit steps of multiply and divide, and hands off the finished beat.
// ----------------------------------------------------------------------------
module sba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  sba_pkg::req_beat_type req_data,
   input  logic                  out_free,
   output sba_pkg::ctrl_type     ctrl
);
   import sba_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_ARITH  = 9'b000000010,
      ST_MUL    = 9'b000000100,
      ST_MULFIN = 9'b000001000,
      ST_NEGA   = 9'b000010000,
      ST_NEGB   = 9'b000100000,
      ST_DIV    = 9'b001000000,
      ST_DIVFIX = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 cnt_last;

   assign cnt_last = (cnt_ff == CNT_WIDTH'(DATA_WIDTH - 1));

   // next state and micro-operation
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctrl.uop  = UOP_NONE;
      ctrl.push = 1'b0;
      ctrl.busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.busy = 1'b0;
            cnt_in    = '0;
            if (req_valid) begin
               case (req_data.req_type)
                  OP_ADD, OP_SUB: begin
                     ctrl.uop = UOP_LOAD_ARITH;
                     state_in = ST_ARITH;
                  end
                  OP_MUL: begin
                     ctrl.uop = UOP_LOAD_MUL;
                     state_in = ST_MUL;
                  end
                  default: begin
                     if (req_data.operand_b == '0) begin
                        ctrl.uop = UOP_LOAD_DIV0;
                        state_in = ST_FINISH;
                     end else begin
                        ctrl.uop = UOP_LOAD_DIV;
                        state_in = ST_NEGA;
                     end
                  end
               endcase
            end
         end
         ST_ARITH: begin
            ctrl.uop = UOP_ARITH;
            state_in = ST_FINISH;
         end
         ST_MUL: begin
            ctrl.uop = UOP_MUL_STEP;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_MULFIN;
            end
         end
         ST_MULFIN: begin
            ctrl.uop = UOP_MUL_FIN;
            state_in = ST_FINISH;
         end
         ST_NEGA: begin
            ctrl.uop = UOP_NEG_A;
            state_in = ST_NEGB;
         end
         ST_NEGB: begin
            ctrl.uop = UOP_NEG_B;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            ctrl.uop = UOP_DIV_STEP;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in   = '0;
               state_in = ST_DIVFIX;
            end
         end
         ST_DIVFIX: begin
            ctrl.uop = UOP_DIV_FIX;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               ctrl.push = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // step counter idles at zero
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_NEGA || state_ff == ST_FINISH) |-> (cnt_ff == '0))
      else $error("step counter not at zero outside a step loop");

   // a step loop only ends after its last step
   a_loop_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MULFIN || state_ff == ST_DIVFIX) |-> $past(cnt_last))
      else $error("step loop left early");

endmodule

// File: sv/signed16_alu_booth_divide.sv
// ----------------------------------------------------------------------------
// signed16_alu_booth_divide
// Signed two's complement add, subtract, booth multiply and restoring divide
// with one result beat and a status per request.
// ----------------------------------------------------------------------------
// One request is in work at a time and req_stall is high during reset and
// until the result of the request in work is handed to the output register.
// Add and subtract use the one shared adder once, multiply and divide use it
// once per operand bit, and divide adds the operand negations before its steps
// and a quotient sign fix after them; a divide by zero goes straight to the
// output hand-off. The output register frees the input side: a new request is
// taken while a result still waits on rsp_stall. Status is ok, overflow (result
// keeps the low bits of the true value) or divide by zero (result is zero).
// ----------------------------------------------------------------------------
module signed16_alu_booth_divide (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sba_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sba_pkg::rsp_beat_type rsp_data
);
   import sba_pkg::*;

   ctrl_type     ctrl;
   rsp_beat_type res_data;
   logic         out_free;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_data_ff, rsp_data_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = ctrl.busy || reset;

   // sequencer
   sba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   // shared adder and working registers
   sba_datapath u_datapath (
      .clock    (clock),
      .uop      (ctrl.uop),
      .req_data (req_data),
      .res_data (res_data)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a finished beat never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> out_free)
      else $error("result pushed over a stalled beat");

   // a pushed beat shows up on the output
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> (rsp_valid && rsp_data == $past(res_data)))
      else $error("pushed result not presented");

endmodule
